// ===== sv/mexp_pkg.sv =====
// ---------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation core: port widths,
// configuration register indexes and their reset values.
// ---------------------------------------------------------------------------
package mexp_pkg;

  localparam int FIELD_W       = 32;
  localparam int DEFAULT_WIDTH = 32;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

  localparam logic [FIELD_W-1:0] EXPONENT_RESET = 32'd1;
  localparam logic [FIELD_W-1:0] MODULUS_RESET  = 32'd2;

endpackage

// ===== sv/mexp_modred.sv =====
// ---------------------------------------------------------------------------
// mexp_modred
// Bit-serial restoring reduction of a double-width value modulo m. The high
// half must already be below m; one low-half bit is folded in per cycle.
// ---------------------------------------------------------------------------
module mexp_modred
  import mexp_pkg::*;
#(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [WIDTH-1:0] hi,
  input  logic [WIDTH-1:0] lo,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] rem
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] sh;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] r_next;

  // Shift one bit in, subtract m when it fits.
  always_comb begin
    trial  = {r, sh[WIDTH-1]};
    diff   = trial - {1'b0, m};
    r_next = (trial >= {1'b0, m}) ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CNT_W'(WIDTH);
        r       <= hi;
        sh      <= lo;
      end else if (running) begin
        r   <= r_next;
        sh  <= {sh[WIDTH-2:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rem = r;

endmodule

// ===== sv/mexp_mulmod.sv =====
// ---------------------------------------------------------------------------
// mexp_mulmod
// Shared modular multiplier: registers the exact double-width product, then
// hands it to the bit-serial reducer.
// ---------------------------------------------------------------------------
module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] rem
);

  localparam int PW = 2 * WIDTH;

  logic [PW-1:0] prod;
  logic          red_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_go <= 1'b0;
    end else begin
      red_go <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      prod <= PW'(a) * PW'(b);
    end
  end

  mexp_modred #(
    .WIDTH (WIDTH)
  ) u_modred (
    .clk  (clk),
    .rst  (rst),
    .go   (red_go),
    .hi   (prod[PW-1:WIDTH]),
    .lo   (prod[WIDTH-1:0]),
    .m    (m),
    .done (done),
    .rem  (rem)
  );

endmodule

// ===== sv/modular_exponentiation_core.sv =====
// ---------------------------------------------------------------------------
// modular_exponentiation_core
// Right-to-left square-and-multiply: block_value ^ key_exponent mod
// key_modulus, one item at a time on a shared modular multiplier.
// ---------------------------------------------------------------------------
// Usage: write key_exponent (index 0) and key_modulus (index 1) while busy is
// low, then pulse start with block_value. busy stays high while the item is
// worked on; the result appears on power_result for exactly one cycle with
// done high, and must be taken then. Every modular multiply runs on one shared
// unit: the product is registered, then loaded into the reducer, reduced
// bit-serially and handed back to the sequencer. An item needs one
// multiply to reduce the base, one per set exponent bit, and one squaring
// per exponent bit below the highest set bit: with WIDTH = 32 at most 64
// multiplies, and only the base reduction for an exponent of zero.
// A modulus below two gives 0 in the cycle after start.
// ---------------------------------------------------------------------------
module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [FIELD_W-1:0]   block_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  output logic                 done,
  output logic [FIELD_W-1:0]   power_result
);

  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for start
  localparam logic [1:0] ST_RED  = 2'd1;  // base mod m in flight
  localparam logic [1:0] ST_MUL  = 2'd2;  // acc * base in flight
  localparam logic [1:0] ST_SQR  = 2'd3;  // base * base in flight

  // Key registers
  logic [FIELD_W-1:0] key_exponent;
  logic [FIELD_W-1:0] key_modulus;

  // Sequencer and working registers
  logic [1:0]       state;
  logic [WIDTH-1:0] expo;
  logic [WIDTH-1:0] modv;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] result;
  logic [WIDTH-1:0] op_a;
  logic [WIDTH-1:0] op_b;
  logic             mm_go;

  logic             mm_done;
  logic [WIDTH-1:0] mm_rem;
  logic [WIDTH-1:0] expo_shr;
  logic [WIDTH-1:0] mod_in;

  assign expo_shr = expo >> 1;
  assign mod_in   = key_modulus[WIDTH-1:0];
  assign busy     = (state != ST_IDLE);

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_exponent <= EXPONENT_RESET;
      key_modulus  <= MODULUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPONENT: key_exponent <= cfg_data;
        REG_MODULUS:  key_modulus  <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Sequencer: each busy state waits for the shared multiplier, folds its result
  // in and issues the next multiply or finishes the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      mm_go <= 1'b0;
    end else begin
      done  <= 1'b0;
      mm_go <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            expo <= key_exponent[WIDTH-1:0];
            modv <= mod_in;
            acc  <= WIDTH'(1);
            if (mod_in < WIDTH'(2)) begin
              // Degenerate modulus (0 or 1): deliver 0.
              result <= '0;
              done   <= 1'b1;
            end else begin
              // Reduce the base first; high product half is zero, below m.
              op_a  <= block_value[WIDTH-1:0];
              op_b  <= WIDTH'(1);
              mm_go <= 1'b1;
              state <= ST_RED;
            end
          end
        end
        ST_RED: begin
          if (mm_done) begin
            op_a <= mm_rem;
            if (expo == '0) begin
              // Zero exponent: deliver 1.
              result <= acc;
              done   <= 1'b1;
              state  <= ST_IDLE;
            end else if (expo[0]) begin
              op_b  <= acc;
              mm_go <= 1'b1;
              state <= ST_MUL;
            end else begin
              op_b  <= mm_rem;
              mm_go <= 1'b1;
              state <= ST_SQR;
            end
          end
        end
        ST_MUL: begin
          if (mm_done) begin
            acc <= mm_rem;
            if (expo_shr == '0) begin
              // No set bits left: skip the final squaring.
              result <= mm_rem;
              done   <= 1'b1;
              state  <= ST_IDLE;
            end else begin
              // op_a still holds the base; square it.
              op_b  <= op_a;
              mm_go <= 1'b1;
              state <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          if (mm_done) begin
            // Advance to the next exponent bit; the remaining exponent is known to be nonzero.
            expo  <= expo_shr;
            op_a  <= mm_rem;
            mm_go <= 1'b1;
            if (expo_shr[0]) begin
              op_b  <= acc;
              state <= ST_MUL;
            end else begin
              op_b  <= mm_rem;
              state <= ST_SQR;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  mexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .go   (mm_go),
    .a    (op_a),
    .b    (op_b),
    .m    (modv),
    .done (mm_done),
    .rem  (mm_rem)
  );

  assign power_result = FIELD_W'(result);

  // Checks
  a_result_below_mod: assert property (@(posedge clk) disable iff (rst)
    (done && modv >= WIDTH'(2)) |-> (result < modv))
    else $error("result not reduced below modulus");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_mm_go_busy: assert property (@(posedge clk) disable iff (rst)
    mm_go |-> busy)
    else $error("multiply issued while idle");

  a_mm_done_busy: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (busy && !mm_go))
    else $error("multiply finished outside an item");

endmodule
